// ----- rtl/core/cbd_pkg.sv -----
`default_nettype none

package cbd_pkg;

    // Storage geometry
    localparam int MAX_WIDTH    = 4096;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int LINE_DEPTH   = MAX_WIDTH / 2;
    localparam int LINE_AW      = $clog2(LINE_DEPTH);

    // Field widths
    localparam int SAMPLE_W = 8;
    localparam int SUM_W    = 9;
    localparam int AVG_W    = 10;
    localparam int COUNT_W  = 12;
    localparam int DIM_W    = 13;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SUB_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    // Subsampling modes
    localparam logic [MODE_W-1:0] MODE_444 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_420 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_422 = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Work carried by the execute stage
    typedef enum logic [1:0] {
        OP_NONE,
        OP_EMIT_PAIR,
        OP_EMIT_BOX,
        OP_STORE
    } op_t;

endpackage

`default_nettype wire

// ----- rtl/core/chroma_box_downsampler_core.sv -----
`default_nettype none

// Channel | Ports                               | Transaction
// --------+-------------------------------------+-------------------------------------
// input   | s_valid s_ready s_sample            | one chroma sample, raster order
// output  | m_valid m_ready m_average_q2        | one box average (x4), frame_end flag
//         | m_frame_end                         |
// config  | cfg_wr_en cfg_index cfg_wr_data     | register write, no wait state
//
// One sample per cycle sustained while results are taken; a result passes the execute
// stage register into the output register (accept/line-buffer read, then execute).
// The line buffer is a 2048 x 9 memory with registered read; a store and a read of
// the same entry in the same cycle are forwarded.
// Reset loads the register defaults and clears counters and pipeline valids; there is
// no clearing pass of the line buffer.
// A stalled output holds the execute stage, which in turn drops s_ready.

module chroma_box_downsampler_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [cbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cbd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [cbd_pkg::SAMPLE_W-1:0]   s_sample,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [cbd_pkg::AVG_W-1:0]           m_average_q2,
    output logic                              m_frame_end
);
    import cbd_pkg::*;

    // Configuration registers
    logic [MODE_W-1:0]  sub_mode_reg;
    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;

    // Position and pair state
    logic [COUNT_W-1:0] col_reg, col_next;
    logic [COUNT_W-1:0] row_reg, row_next;
    logic [SUM_W-1:0]   pair_reg, pair_next;

    // Execute stage
    logic               s1_valid_reg, s1_valid_next;
    op_t                s1_op_reg, s1_op_next;
    logic [SUM_W-1:0]   s1_sum_reg, s1_sum_next;
    logic               s1_full_reg, s1_full_next;
    logic               s1_end_reg, s1_end_next;
    logic [LINE_AW-1:0] s1_idx_reg;

    // Output register
    logic               m_valid_reg, m_valid_next;
    logic [AVG_W-1:0]   m_avg_reg;
    logic               m_end_reg;

    // Line buffer
    logic [SUM_W-1:0]   line_mem [LINE_DEPTH];
    logic [SUM_W-1:0]   mem_q_reg;
    logic [LINE_AW-1:0] rd_addr;
    logic               mem_we;
    logic               fwd_hit_reg;
    logic [SUM_W-1:0]   fwd_data_reg;

    logic               s_fire;
    logic               s1_emit;
    logic               s1_adv;
    logic [COUNT_W-1:0] w_last;
    logic [COUNT_W-1:0] h_last;
    logic               last_col;
    logic               last_row;
    logic               odd_col;
    logic               odd_row;
    logic [LINE_AW-1:0] col_idx;
    logic [SUM_W-1:0]   line_val;
    logic [AVG_W-1:0]   box_sum;
    logic [AVG_W-1:0]   avg_val;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_mode_reg     <= MODE_420;
            frame_width_reg  <= DIM_W'(MAX_WIDTH);
            frame_height_reg <= DIM_W'(HEIGHT_LIMIT);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SUB_MODE:     sub_mode_reg     <= cfg_wr_data[MODE_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wr_data[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the frame size to its last column and row
    always_comb begin
        if (frame_width_reg == '0) begin
            w_last = '0;
        end else if (frame_width_reg > DIM_W'(MAX_WIDTH)) begin
            w_last = COUNT_W'(MAX_WIDTH - 1);
        end else begin
            w_last = COUNT_W'(frame_width_reg - DIM_W'(1));
        end
        if (frame_height_reg == '0) begin
            h_last = '0;
        end else if (frame_height_reg > DIM_W'(HEIGHT_LIMIT)) begin
            h_last = COUNT_W'(HEIGHT_LIMIT - 1);
        end else begin
            h_last = COUNT_W'(frame_height_reg - DIM_W'(1));
        end
    end

    assign last_col = col_reg >= w_last;
    assign last_row = row_reg >= h_last;
    assign odd_col  = col_reg[0];
    assign odd_row  = row_reg[0];
    assign col_idx  = col_reg[LINE_AW:1];

    // Handshake: the execute stage moves on unless its result meets a full output
    assign s1_emit = (s1_op_reg == OP_EMIT_PAIR) || (s1_op_reg == OP_EMIT_BOX);
    assign s1_adv  = s1_valid_reg && (!s1_emit || !m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign s_fire  = s_valid && s_ready;

    // Decode the accepted sample into counters, pair sum and execute-stage work
    always_comb begin
        col_next      = col_reg;
        row_next      = row_reg;
        pair_next     = pair_reg;
        s1_op_next    = s1_op_reg;
        s1_sum_next   = s1_sum_reg;
        s1_full_next  = s1_full_reg;
        s1_end_next   = s1_end_reg;
        s1_valid_next = s1_valid_reg;
        if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        if (s_fire) begin
            s1_valid_next = 1'b1;
            s1_end_next   = last_col && last_row;
            case (sub_mode_reg) inside
                MODE_420, MODE_422: begin
                    if (odd_col) begin
                        pair_next = SUM_W'(pair_reg + SUM_W'(s_sample));
                    end else begin
                        pair_next = SUM_W'(s_sample);
                    end
                    s1_sum_next  = pair_next;
                    s1_full_next = odd_col;
                    if (!(odd_col || last_col)) begin
                        s1_op_next = OP_NONE;
                    end else if (sub_mode_reg == MODE_422) begin
                        s1_op_next = OP_EMIT_PAIR;
                    end else if (odd_row) begin
                        s1_op_next = OP_EMIT_BOX;
                    end else if (last_row) begin
                        s1_op_next = OP_EMIT_PAIR;
                    end else begin
                        s1_op_next = OP_STORE;
                    end
                end
                default: begin
                    // Copy mode: a single sample scaled like a one-sample pair
                    s1_sum_next  = SUM_W'(s_sample);
                    s1_full_next = 1'b0;
                    s1_op_next   = OP_EMIT_PAIR;
                end
            endcase
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : COUNT_W'(row_reg + COUNT_W'(1));
            end else begin
                col_next = COUNT_W'(col_reg + COUNT_W'(1));
            end
        end
    end

    // Advance counters and execute-stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            pair_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= OP_NONE;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            pair_reg     <= pair_next;
            s1_valid_reg <= s1_valid_next;
            s1_op_reg    <= s1_op_next;
        end
    end

    // Hold execute-stage payload
    always_ff @(posedge aclk) begin
        s1_sum_reg  <= s1_sum_next;
        s1_full_reg <= s1_full_next;
        s1_end_reg  <= s1_end_next;
        if (s_fire) begin
            s1_idx_reg <= col_idx;
        end
    end

    // Line buffer: read for the entering sample, or re-read while the stage holds
    assign rd_addr = s_fire ? col_idx : s1_idx_reg;
    assign mem_we  = s1_adv && (s1_op_reg == OP_STORE);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            line_mem[s1_idx_reg] <= s1_sum_reg;
        end
    end

    always_ff @(posedge aclk) begin
        mem_q_reg <= line_mem[rd_addr];
    end

    // Forward a store that collides with the read of the same entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else begin
            fwd_hit_reg <= mem_we && (s1_idx_reg == rd_addr);
        end
        fwd_data_reg <= s1_sum_reg;
    end

    assign line_val = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

    // Scale the box sum to the average times four
    assign box_sum = AVG_W'(line_val) + AVG_W'(s1_sum_reg);

    always_comb begin
        if (s1_op_reg == OP_EMIT_BOX) begin
            avg_val = s1_full_reg ? box_sum : AVG_W'({box_sum, 1'b0});
        end else begin
            avg_val = s1_full_reg ? AVG_W'({s1_sum_reg, 1'b0})
                                  : AVG_W'({s1_sum_reg, 2'b00});
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s1_adv && s1_emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_emit) begin
            m_avg_reg <= avg_val;
            m_end_reg <= s1_end_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_average_q2 = m_avg_reg;
    assign m_frame_end  = m_end_reg;

`ifndef SYNTH
    // A held execute stage keeps its work
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_op_reg)))
        else $error("execute stage lost its transaction while stalled");

    // The last sample of a frame returns both counters to the origin
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && last_col && last_row) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters did not wrap at frame end");

    // A waiting result is never overwritten by the execute stage
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && s1_valid_reg && s1_emit)
        |=> (m_valid_reg && $stable(m_avg_reg) && $stable(m_end_reg)))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ----- tb/chroma_box_downsampler_core_test.sv -----
`timescale 1ns / 100ps

module chroma_box_downsampler_core_test;
    import cbd_pkg::*;

    localparam int RESET_CYCLES         = 12;
    localparam int SETTLE_CYCLES        = 8;
    localparam int RESET_PROBE_SAMPLES  = 16;
    localparam int LIMIT_PROBE_SAMPLES  = 24;
    localparam int RANDOM_SAMPLES       = 1550;
    localparam int STEADY_FROM          = 600;
    localparam int STEADY_TO            = 900;
    localparam int END_WAIT_LIMIT       = 2000;
    localparam int TIMEOUT_NS           = 200000;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [AVG_W-1:0] average_q2;
        logic             frame_end;
    } box_result_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_sample    = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [AVG_W-1:0]      m_average_q2;
    logic                  m_frame_end;

    // Register copies, at their reset values
    logic [MODE_W-1:0]     mode_now   = MODE_420;
    logic [DIM_W-1:0]      width_now  = DIM_W'(MAX_WIDTH);
    logic [DIM_W-1:0]      height_now = DIM_W'(HEIGHT_LIMIT);

    // Position, open pair and upper-row pair sums of the predicted block
    logic [COUNT_W-1:0]    column_at = '0;
    logic [COUNT_W-1:0]    row_at    = '0;
    logic [SUM_W-1:0]      pair_run  = '0;
    logic [SUM_W-1:0]      upper_pairs [LINE_DEPTH];

    box_result_t           box_results_due [$];
    int                    error_count  = 0;
    int                    samples_sent = 0;
    bit                    steady_flow  = 1'b0;

    chroma_box_downsampler_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_average_q2 (m_average_q2),
        .m_frame_end  (m_frame_end)
    );

    always #2 aclk = ~aclk;

    // Stall the result channel at random, except during the steady stretch
    always @(negedge aclk) begin
        m_ready <= steady_flow || ($urandom_range(99) >= 31);
    end

    // Scale a box sum of one, two or four samples to quarter units
    function automatic logic [AVG_W-1:0] quarter_units(input int sum, input int count);
        case (count)
            1: return AVG_W'(sum << 2);
            2: return AVG_W'(sum << 1);
            default: return AVG_W'(sum);
        endcase
    endfunction

    // Advance the predicted block by one sample; queue the box it completes
    task automatic predict_box(input logic [SAMPLE_W-1:0] s);
        int                  w;
        int                  h;
        int                  count;
        logic                last_col;
        logic                last_row;
        logic                odd_col;
        logic                odd_row;
        logic                emit;
        logic [LINE_AW-1:0]  slot;
        box_result_t         box;
        w = (width_now == 0) ? 1 : (width_now > MAX_WIDTH) ? MAX_WIDTH : int'(width_now);
        h = (height_now == 0) ? 1 :
            (height_now > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_now);
        last_col = (column_at >= w - 1);
        last_row = (row_at >= h - 1);
        odd_col  = column_at[0];
        odd_row  = row_at[0];
        slot     = column_at[COUNT_W-1:1];
        emit     = 1'b0;
        box.average_q2 = '0;

        if (mode_now == MODE_420 || mode_now == MODE_422) begin
            pair_run = odd_col ? pair_run + s : {1'b0, s};
            if (odd_col || last_col) begin
                count = odd_col ? 2 : 1;
                if (mode_now == MODE_422) begin
                    emit = 1'b1;
                    box.average_q2 = quarter_units(pair_run, count);
                end else if (odd_row) begin
                    emit = 1'b1;
                    box.average_q2 = quarter_units(upper_pairs[slot] + pair_run, 2 * count);
                end else if (last_row) begin
                    // bottom row of an odd height: the box has no lower half
                    emit = 1'b1;
                    box.average_q2 = quarter_units(pair_run, count);
                end else begin
                    upper_pairs[slot] = pair_run;
                end
            end
        end else begin
            emit = 1'b1;
            box.average_q2 = quarter_units(s, 1);
        end

        box.frame_end = last_col && last_row;
        if (emit) box_results_due.push_back(box);

        if (last_col) begin
            column_at = '0;
            row_at    = last_row ? '0 : row_at + 1'b1;
        end else begin
            column_at = column_at + 1'b1;
        end
    endtask

    // Check each result against the oldest expectation; predict each accepted sample
    always @(posedge aclk) begin : check_results
        box_result_t due;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (box_results_due.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual %0d/%0b",
                             $time, m_average_q2, m_frame_end);
                end else begin
                    due = box_results_due.pop_front();
                    if (m_average_q2 !== due.average_q2) begin
                        error_count++;
                        $display("%0t: average_q2 expected %0d actual %0d",
                                 $time, due.average_q2, m_average_q2);
                    end
                    if (m_frame_end !== due.frame_end) begin
                        error_count++;
                        $display("%0t: frame_end expected %0b actual %0b",
                                 $time, due.frame_end, m_frame_end);
                    end
                end
            end
            if (s_valid && s_ready) predict_box(s_sample);
        end
    end

    // Offer one sample, idling at random first; hold it until the transaction completes
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        @(negedge aclk);
        while (!steady_flow && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
    endtask

    task automatic quiet_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // Drain the block, then write one register
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        quiet_input();
        while (box_results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= data;
        case (index)
            REG_SUB_MODE:     mode_now   = data[MODE_W-1:0];
            REG_FRAME_WIDTH:  width_now  = data;
            REG_FRAME_HEIGHT: height_now = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Write all three registers; mode data carries random upper bits
    task automatic configure(input logic [MODE_W-1:0] mode, input int w, input int h);
        logic [CFG_DATA_W-1:0] mode_data;
        mode_data = CFG_DATA_W'($urandom);
        mode_data[MODE_W-1:0] = mode;
        write_register(REG_SUB_MODE, mode_data);
        write_register(REG_FRAME_WIDTH, CFG_DATA_W'(w));
        write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    endtask

    // Force both counters back to zero: a 1x1 frame wraps column and row at once
    task automatic realign_frame();
        configure(MODE_444, 1, 1);
        send_sample(SAMPLE_W'($urandom_range(0, 255)));
    endtask

    // Reset configuration: 4:2:0 on a wide, tall frame, so the first row only stores
    task automatic test_reset_defaults();
        repeat (RESET_PROBE_SAMPLES) send_sample(SAMPLE_W'($urandom_range(0, 255)));
        realign_frame();
    endtask

    // One small frame per mode, odd sizes for partial boxes, extreme samples
    task automatic test_every_mode();
        write_register(REG_UNMAPPED, '1);
        configure(MODE_420, 3, 3);
        for (int i = 0; i < 9; i++) send_sample((i % 4 == 3) ? 8'd0 : 8'd255);
        configure(MODE_422, 3, 2);
        for (int i = 0; i < 6; i++) send_sample(i[0] ? 8'd0 : 8'd255);
        configure(MODE_444, 2, 1);
        send_sample(8'd0);
        send_sample(8'd255);
        configure(MODE_UNUSED, 2, 2);
        for (int i = 0; i < 4; i++) send_sample(SAMPLE_W'(i * 85));
    endtask

    // Zero sizes act as one; sizes beyond the limits clamp and keep the frame long
    task automatic test_dimension_limits();
        configure(MODE_420, 0, 0);
        send_sample(8'd255);
        send_sample(8'd0);
        configure(MODE_444, 8191, 1);
        repeat (LIMIT_PROBE_SAMPLES) send_sample(SAMPLE_W'($urandom_range(0, 255)));
        write_register(REG_FRAME_WIDTH, CFG_DATA_W'(1));
        write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(8191));
        repeat (LIMIT_PROBE_SAMPLES) send_sample(SAMPLE_W'($urandom_range(0, 255)));
        realign_frame();
    endtask

    // Shrink width and height in the middle of a 4:2:2 frame
    task automatic test_mid_frame_change();
        configure(MODE_422, 6, 4);
        repeat (3) send_sample(SAMPLE_W'($urandom_range(0, 255)));
        // column now past the new last column: close the pair and wrap
        write_register(REG_FRAME_WIDTH, CFG_DATA_W'(2));
        repeat (3) send_sample(SAMPLE_W'($urandom_range(0, 255)));
        // current row becomes the last one
        write_register(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
        repeat (4) send_sample(SAMPLE_W'($urandom_range(0, 255)));
        realign_frame();
    endtask

    // Whole frames under random settings, some cut short and realigned
    task automatic test_random_frames();
        int                  start;
        int                  w;
        int                  h;
        int                  frame_len;
        int                  pick;
        bit                  need_config;
        logic [MODE_W-1:0]   mode;
        logic [SAMPLE_W-1:0] value;
        start       = samples_sent;
        need_config = 1'b1;
        w = 1;
        h = 1;
        while (samples_sent - start < RANDOM_SAMPLES) begin
            if (need_config || $urandom_range(99) < 60) begin
                pick = $urandom_range(99);
                mode = (pick < 50) ? MODE_420 : (pick < 75) ? MODE_422 :
                       (pick < 93) ? MODE_444 : MODE_UNUSED;
                if ($urandom_range(99) < 6) begin
                    w = $urandom_range(300, 700);
                    h = $urandom_range(1, 2);
                end else begin
                    w = $urandom_range(0, 24);
                    h = $urandom_range(0, 9);
                end
                configure(mode, w, h);
                need_config = 1'b0;
            end
            frame_len = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            if (frame_len > 1 && $urandom_range(99) < 10) begin
                frame_len   = $urandom_range(1, frame_len - 1);
                need_config = 1'b1;
            end
            repeat (frame_len) begin
                steady_flow = (samples_sent - start >= STEADY_FROM) &&
                              (samples_sent - start < STEADY_TO);
                if ($urandom_range(99) < 15)
                    value = $urandom_range(1) ? 8'hFF : 8'h00;
                else
                    value = SAMPLE_W'($urandom_range(0, 255));
                send_sample(value);
            end
            if (need_config) realign_frame();
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int guard;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_every_mode();
        test_dimension_limits();
        test_mid_frame_change();
        test_random_frames();

        // Drain the pipeline and catch any stray result
        quiet_input();
        guard = 0;
        while (box_results_due.size() != 0 && guard < END_WAIT_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (box_results_due.size() != 0) begin
            error_count++;
            $display("%0t: results expected %0d more, actual 0", $time,
                     box_results_due.size());
        end

        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/cbd_pkg.sv
rtl/core/chroma_box_downsampler_core.sv
tb/chroma_box_downsampler_core_test.sv
